@@ sv/clip_pkg.sv @@
// Package for the C integer literal parser: character codes, parse modes,
// type codes, the parse state and the request and result payload structs.
// No dependencies.
`timescale 1ns / 1ps

package clip_pkg;

    // Width of the value accumulator; values wrap modulo 2^VALUE_WIDTH (32..64).
    localparam int VALUE_WIDTH = 64;

    // ASCII codes used by the parser.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_L  = 8'h4C;
    localparam logic [7:0] CH_UP_U  = 8'h55;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_L  = 8'h6C;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // Phase of the parse.
    typedef enum logic [3:0] {
        MODE_START = 4'd0,
        MODE_ZERO  = 4'd1,
        MODE_HEX   = 4'd2,
        MODE_OCT   = 4'd3,
        MODE_DEC   = 4'd4,
        MODE_U     = 4'd5,
        MODE_L     = 4'd6,
        MODE_UL    = 4'd7,
        MODE_LL    = 4'd8,
        MODE_DONE  = 4'd9
    } t_mode;

    // Type of the literal.
    typedef enum logic [2:0] {
        TY_INT    = 3'd0,
        TY_UINT   = 3'd1,
        TY_LONG   = 3'd2,
        TY_ULONG  = 3'd3,
        TY_LLONG  = 3'd4,
        TY_ULLONG = 3'd5
    } t_ltype;

    // Parse state carried from one character to the next.
    typedef struct packed {
        t_mode                  mode;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   first_l_upper;
        t_ltype                 ptype;
    } t_parse_state;

    localparam t_parse_state ST_RESET = '{
        mode:          MODE_START,
        acc:           '0,
        first_l_upper: 1'b0,
        ptype:         TY_INT
    };

    // One request: a character of the token.
    typedef struct packed {
        logic [7:0] char_code;
        logic       token_end;
    } t_lit_in;

    // One result: the value and type of a finished token.
    typedef struct packed {
        logic [63:0] literal_value;
        logic [2:0]  type_code;
    } t_lit_out;

endpackage

@@ sv/c_integer_literal_parser_unit.sv @@
// Top level of the C integer literal parser: input register, parse state,
// result register. Depends on clip_pkg and clip_step.
`timescale 1ns / 1ps

// The parser takes one character of a C integer constant per request and
// sustains one character per cycle. A result (value modulo 2^VALUE_WIDTH
// and a type code) is registered once the request that carries token_end
// leaves the input register; that rate rests on the combinational update of
// the parse mode and the 64-bit accumulator (shift-and-add times ten for
// decimal). The result register holds a finished result while new characters
// keep flowing in; only a second final character waits on a stalled result.
// After each token the parse state returns to the start of a token.
module c_integer_literal_parser_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  clip_pkg::t_lit_in  i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output clip_pkg::t_lit_out o_rsp
);
    import clip_pkg::*;

    logic         r_in_valid;
    t_lit_in      r_in;
    t_parse_state r_st;
    t_parse_state w_st_next;
    logic         r_out_valid;
    t_lit_out     r_out;
    logic         w_adv;
    logic         w_accept;

    // A character moves on unless it ends a token and the result slot is held.
    assign w_adv       = r_in_valid && (!r_in.token_end || !r_out_valid || !i_rsp_stall);
    assign o_req_stall = r_in_valid && !w_adv;
    assign w_accept    = i_req_valid && !o_req_stall;

    // Per-character parse step.
    clip_step u_step (
        .i_char  (r_in.char_code),
        .i_state (r_st),
        .o_state (w_st_next)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_req;
        end
    end

    // Parse state; a final character returns it to the start of a token.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else if (w_adv) begin
            r_st <= r_in.token_end ? ST_RESET : w_st_next;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in.token_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in.token_end) begin
            r_out.literal_value <= 64'(w_st_next.acc);
            r_out.type_code     <= 3'(w_st_next.ptype);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

@@ sv/clip_step.sv @@
// Single-character update of the literal parse state.
// Purely combinational; depends on clip_pkg.
`timescale 1ns / 1ps

module clip_step (
    input  logic [7:0]            i_char,
    input  clip_pkg::t_parse_state i_state,
    output clip_pkg::t_parse_state o_state
);
    import clip_pkg::*;

    logic                   w_is_dec;
    logic                   w_is_oct;
    logic                   w_is_hex_lo;
    logic                   w_is_hex_up;
    logic                   w_is_hex;
    logic                   w_is_u;
    logic                   w_is_l;
    logic                   w_is_up_l;
    logic                   w_is_x;
    logic                   w_same_l;
    logic [3:0]             w_digit;
    logic [VALUE_WIDTH-1:0] w_acc_dec;
    logic [VALUE_WIDTH-1:0] w_acc_oct;
    logic [VALUE_WIDTH-1:0] w_acc_hex;
    t_mode                  n_mode;

    // Character classes.
    assign w_is_dec    = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_is_oct    = (i_char >= CH_ZERO) && (i_char <= CH_SEVEN);
    assign w_is_hex_lo = (i_char >= CH_LO_A) && (i_char <= CH_LO_F);
    assign w_is_hex_up = (i_char >= CH_UP_A) && (i_char <= CH_UP_F);
    assign w_is_hex    = w_is_dec || w_is_hex_lo || w_is_hex_up;
    assign w_is_u      = (i_char == CH_LO_U) || (i_char == CH_UP_U);
    assign w_is_up_l   = (i_char == CH_UP_L);
    assign w_is_l      = (i_char == CH_LO_L) || w_is_up_l;
    assign w_is_x      = (i_char == CH_LO_X) || (i_char == CH_UP_X);
    assign w_same_l    = i_state.first_l_upper ? w_is_up_l : (i_char == CH_LO_L);

    // Digit value: a decimal digit is its low nibble, a hex letter is nibble plus nine.
    assign w_digit = w_is_dec ? i_char[3:0] : 4'(i_char[3:0] + 4'd9);

    // Accumulator updates for each radix; times ten is a shift-and-add.
    assign w_acc_dec = (i_state.acc << 3) + (i_state.acc << 1) + VALUE_WIDTH'(w_digit);
    assign w_acc_oct = {i_state.acc[VALUE_WIDTH-4:0], w_digit[2:0]};
    assign w_acc_hex = {i_state.acc[VALUE_WIDTH-5:0], w_digit};

    // Next parse mode.
    always_comb begin
        n_mode = MODE_DONE;
        unique case (i_state.mode)
            MODE_START: begin
                if (i_char == CH_ZERO)                          n_mode = MODE_ZERO;
                else if (i_char >= CH_ONE && i_char <= CH_NINE) n_mode = MODE_DEC;
                else if (w_is_u)                                n_mode = MODE_U;
                else if (w_is_l)                                n_mode = MODE_L;
            end
            MODE_ZERO: begin
                if (w_is_x)        n_mode = MODE_HEX;
                else if (w_is_oct) n_mode = MODE_OCT;
                else if (w_is_u)   n_mode = MODE_U;
                else if (w_is_l)   n_mode = MODE_L;
            end
            MODE_HEX: begin
                if (w_is_hex)    n_mode = MODE_HEX;
                else if (w_is_u) n_mode = MODE_U;
                else if (w_is_l) n_mode = MODE_L;
            end
            MODE_OCT: begin
                if (w_is_oct)    n_mode = MODE_OCT;
                else if (w_is_u) n_mode = MODE_U;
                else if (w_is_l) n_mode = MODE_L;
            end
            MODE_DEC: begin
                if (w_is_dec)    n_mode = MODE_DEC;
                else if (w_is_u) n_mode = MODE_U;
                else if (w_is_l) n_mode = MODE_L;
            end
            MODE_U: begin
                if (w_is_l) n_mode = MODE_UL;
            end
            MODE_L: begin
                if (w_same_l) n_mode = MODE_LL;
            end
            default: n_mode = MODE_DONE;
        endcase
    end

    // Accumulator, first-L case and pending type.
    always_comb begin
        o_state      = i_state;
        o_state.mode = n_mode;
        case (i_state.mode) inside
            MODE_START, MODE_ZERO, MODE_HEX, MODE_OCT, MODE_DEC: begin
                // A digit updates the accumulator; the first suffix character sets the type, any other ends as int.
                if (n_mode == MODE_U) begin
                    o_state.ptype = TY_UINT;
                end else if (n_mode == MODE_L) begin
                    o_state.ptype         = TY_LONG;
                    o_state.first_l_upper = w_is_up_l;
                end else if (n_mode == MODE_DONE) begin
                    o_state.ptype = TY_INT;
                end else if (i_state.mode == MODE_START && n_mode == MODE_DEC) begin
                    o_state.acc = VALUE_WIDTH'(w_digit);
                end else if (i_state.mode == MODE_ZERO && n_mode == MODE_OCT) begin
                    o_state.acc = VALUE_WIDTH'(w_digit);
                end else if (i_state.mode == MODE_HEX) begin
                    o_state.acc = w_acc_hex;
                end else if (i_state.mode == MODE_OCT) begin
                    o_state.acc = w_acc_oct;
                end else if (i_state.mode == MODE_DEC) begin
                    o_state.acc = w_acc_dec;
                end
            end
            MODE_U: begin
                if (w_is_l) begin
                    o_state.ptype         = TY_ULONG;
                    o_state.first_l_upper = w_is_up_l;
                end
            end
            MODE_UL: begin
                if (w_same_l) o_state.ptype = TY_ULLONG;
            end
            MODE_L: begin
                if (w_same_l)    o_state.ptype = TY_LLONG;
                else if (w_is_u) o_state.ptype = TY_ULONG;
            end
            MODE_LL: begin
                if (w_is_u) o_state.ptype = TY_ULLONG;
            end
            default: ;
        endcase
    end

endmodule
